// File: rtl/core/point_row_edge_feature_detector_core_macros.svh
// Assertion macros for the point row edge detector.
`ifndef POINT_ROW_EDGE_FEATURE_DETECTOR_CORE_MACROS_SVH
`define POINT_ROW_EDGE_FEATURE_DETECTOR_CORE_MACROS_SVH

`ifndef SYNTHESIS
`define PREFD_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("prefd: same-cycle check failed");
`define PREFD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("prefd: next-cycle check failed");
`else
`define PREFD_ASSERT_IMPL(label, ante, cons)
`define PREFD_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// File: rtl/core/prefd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// prefd_pkg
// Shared types and constants of the point row edge feature detector.
// ----------------------------------------------------------------------------
package prefd_pkg;

    localparam int COORD_W    = 16;
    localparam int THR_W      = 18;
    localparam int THR_FRAC   = 16;
    localparam int COL_W      = 10;
    localparam int DIST_W     = 25;               // Q.8 distance width
    localparam int SQ_W       = 2 * COORD_W + 2;  // sum of three squares
    localparam int ROOT_IN_W  = SQ_W + 16;        // dist_sq scaled by 2^16

    localparam logic [THR_W-1:0] THR_RESET = 18'd6554;

    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
    } point_t;

    typedef struct packed {
        logic accept;
        logic diff_step;
        logic sqrt_start;
        logic accum;
        logic fin_square;
        logic fin_mul_lo;
        logic fin_mul_hi;
        logic fin_compare;
        logic emit_reg;
        logic emit_flush;
        logic row_clear;
    } ctrl_cmd_t;

    typedef struct packed {
        logic last;
        logic c_ge_w;
        logic c_ge_2w;
        logic axis_last;
        logic sqrt_done;
        logic nb_last;
        logic flush_last;
        logic out_free;
    } ctrl_status_t;

endpackage

`default_nettype wire

// File: rtl/core/prefd_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// prefd_if
// Valid/ready channels: points in, edge flags out.
// ----------------------------------------------------------------------------
interface prefd_point_if;
    import prefd_pkg::*;

    logic                      valid;
    logic                      ready;
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    logic signed [COORD_W-1:0] point_z;
    logic                      row_end;

    modport source (output valid, point_x, point_y, point_z, row_end, input ready);
    modport sink   (input valid, point_x, point_y, point_z, row_end, output ready);
endinterface

interface prefd_flag_if;
    import prefd_pkg::*;

    logic             valid;
    logic             ready;
    logic             edge_flag;
    logic [COL_W-1:0] column_index;
    logic             row_done;

    modport source (output valid, edge_flag, column_index, row_done, input ready);
    modport sink   (input valid, edge_flag, column_index, row_done, output ready);
endinterface

`default_nettype wire

// File: rtl/core/point_row_edge_feature_detector_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// point_row_edge_feature_detector_core
// Edge feature detector on one scan row of range-sensor points.
// ----------------------------------------------------------------------------
// Points enter on the valid/ready channel "points" in column order; row_end
// marks the last point of a row. Edge flags leave on "flags", each tagged with
// its column, WINDOW_HALF points after the column arrived; a row end flushes
// the trailing columns (never edges), the last one carrying row_done.
// curvature_threshold (Q2.16) is written through cfg_write_en/cfg_write_data.
// Points are taken one at a time. A point at a column of 2*WINDOW_HALF or
// more runs its neighbour distances through the shared square-root unit,
// one after another, each after its x, y and z difference steps, for
// 2*WINDOW_HALF neighbours, then the curvature test. Columns below
// WINDOW_HALF emit nothing and the next WINDOW_HALF columns emit without a
// test; a row end adds one flushed flag per trailing column.
// A finished flag waits in the output register while the next point is taken.
// If the receiver stalls, the sequencer holds at the next emission and points
// are refused. Reset empties the window, clears the column count and the
// output, and loads the threshold default 0.1.
// ----------------------------------------------------------------------------
module point_row_edge_feature_detector_core #(
    parameter int ROW_POINTS_MAX = 1024,
    parameter int WINDOW_HALF    = 2
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    prefd_point_if.sink                      points,
    prefd_flag_if.source                     flags,
    input  wire logic                        cfg_write_en,
    input  wire logic [prefd_pkg::THR_W-1:0] cfg_write_data
);
    import prefd_pkg::*;

    ctrl_cmd_t    cmd;
    ctrl_status_t st;
    logic         in_ready;

    assign points.ready = in_ready;

    prefd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (points.valid),
        .in_ready (in_ready),
        .st       (st),
        .cmd      (cmd)
    );

    prefd_datapath #(
        .ROW_POINTS_MAX (ROW_POINTS_MAX),
        .WINDOW_HALF    (WINDOW_HALF)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .st             (st),
        .point_x        (points.point_x),
        .point_y        (points.point_y),
        .point_z        (points.point_z),
        .row_end        (points.row_end),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .flags          (flags)
    );

endmodule

`default_nettype wire

// File: rtl/core/prefd_sqrt.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// prefd_sqrt
// Iterative integer square root, one result bit per cycle.
// ----------------------------------------------------------------------------
module prefd_sqrt (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            start,
    input  wire logic [prefd_pkg::ROOT_IN_W-1:0] value,
    output logic      [prefd_pkg::DIST_W-1:0]    root,
    output logic                                 busy
);
    import prefd_pkg::*;

    localparam int RW = ROOT_IN_W + 1;
    localparam int CNTW = $clog2(DIST_W);

    logic [RW-1:0]   v_reg;
    logic [RW-1:0]   res_reg;
    logic [RW-1:0]   bit_reg;
    logic [CNTW-1:0] cnt_reg;
    logic            busy_reg;
    logic [RW-1:0]   trial;

    assign trial = res_reg + bit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
        end
        else if (busy_reg && (cnt_reg == CNTW'(DIST_W - 1)))
        begin
            busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            v_reg   <= RW'(value);
            res_reg <= '0;
            bit_reg <= RW'(1) << (ROOT_IN_W - 2);
            cnt_reg <= '0;
        end
        else if (busy_reg)
        begin
            if (v_reg >= trial)
            begin
                v_reg   <= v_reg - trial;
                res_reg <= (res_reg >> 1) + bit_reg;
            end
            else
            begin
                res_reg <= res_reg >> 1;
            end
            bit_reg <= bit_reg >> 2;
            cnt_reg <= cnt_reg + CNTW'(1);
        end
    end

    assign root = res_reg[DIST_W-1:0];
    assign busy = busy_reg;

endmodule

`default_nettype wire

// File: rtl/core/prefd_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// prefd_datapath
// Point window, distance accumulation, curvature test and output register.
// ----------------------------------------------------------------------------
module prefd_datapath #(
    parameter int ROW_POINTS_MAX = 1024,
    parameter int WINDOW_HALF    = 2
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire prefd_pkg::ctrl_cmd_t           cmd,
    output prefd_pkg::ctrl_status_t             st,
    input  wire logic signed [prefd_pkg::COORD_W-1:0] point_x,
    input  wire logic signed [prefd_pkg::COORD_W-1:0] point_y,
    input  wire logic signed [prefd_pkg::COORD_W-1:0] point_z,
    input  wire logic                           row_end,
    input  wire logic                           cfg_write_en,
    input  wire logic [prefd_pkg::THR_W-1:0]    cfg_write_data,
    prefd_flag_if.source                        flags
);
    import prefd_pkg::*;

    localparam int WL   = 2 * WINDOW_HALF + 1;
    localparam int NB   = 2 * WINDOW_HALF;
    localparam int IW   = $clog2(WL);
    localparam int NBC  = $clog2(NB);
    localparam int CW   = $clog2(ROW_POINTS_MAX);
    localparam int SW   = DIST_W + NBC;
    localparam int QW   = 2 * DIST_W + NBC;
    localparam int NQW  = QW + $clog2(NB + 1);
    localparam int S2W  = 2 * SW;
    localparam int HALF = (S2W + 1) / 2;
    localparam int LHSW = NQW + THR_FRAC;
    localparam int RHSW = THR_W + S2W;
    localparam int CMPW = ((LHSW > RHSW) ? LHSW : RHSW) + 1;

    point_t                 win_reg [WL];
    logic [CW-1:0]          counter_reg;
    logic [CW-1:0]          c_reg;
    logic [CW-1:0]          k_reg;
    logic                   last_reg;
    logic                   c_ge_w_reg;
    logic                   c_ge_2w_reg;
    logic [NBC-1:0]         nb_reg;
    logic [1:0]             axis_reg;
    logic [SQ_W-1:0]        sq_reg;
    logic [SW-1:0]          s_reg;
    logic [QW-1:0]          q_reg;
    logic [S2W-1:0]         s2_reg;
    logic [NQW-1:0]         nq_reg;
    logic [NQW-1:0]         num_reg;
    logic [THR_W+HALF-1:0]  plo_reg;
    logic [RHSW-HALF-1:0]   phi_reg;
    logic                   edge_reg;
    logic [THR_W-1:0]       thr_reg;
    logic                   out_valid_reg;
    logic                   out_flag_reg;
    logic [COL_W-1:0]       out_col_reg;
    logic                   out_done_reg;

    logic                      last_in;
    logic                      ge_w_in;
    logic                      ge_2w_in;
    logic [IW-1:0]             nb_idx;
    point_t                    centre;
    point_t                    nbr;
    logic signed [COORD_W-1:0] coord_a;
    logic signed [COORD_W-1:0] coord_b;
    logic signed [COORD_W:0]   diff;
    logic [COORD_W:0]          mag;
    logic [2*COORD_W-1:0]      sq_term;
    logic [DIST_W-1:0]         root_q8;
    logic                      root_busy;
    logic [2*DIST_W-1:0]       dist_sq;
    logic [CMPW-1:0]           lhs;
    logic [CMPW-1:0]           rhs;
    logic [CW-1:0]             reg_col;
    logic [CW+COL_W-1:0]       reg_col_ext;
    logic [CW+COL_W-1:0]       k_col_ext;
    logic                      out_free;

    assign last_in  = row_end || (32'(counter_reg) >= 32'(ROW_POINTS_MAX - 1));
    assign ge_w_in  = 32'(counter_reg) >= 32'(WINDOW_HALF);
    assign ge_2w_in = 32'(counter_reg) >= 32'(NB);

    // neighbour order skips the centre tap
    assign nb_idx = (32'(nb_reg) < 32'(WINDOW_HALF)) ? IW'(nb_reg) : IW'(nb_reg) + IW'(1);
    assign centre = win_reg[WINDOW_HALF];
    assign nbr    = win_reg[nb_idx];

    always_comb
    begin
        unique case (axis_reg)
            AXIS_X:
            begin
                coord_a = centre.x;
                coord_b = nbr.x;
            end
            AXIS_Y:
            begin
                coord_a = centre.y;
                coord_b = nbr.y;
            end
            default:
            begin
                coord_a = centre.z;
                coord_b = nbr.z;
            end
        endcase
    end

    assign diff    = (COORD_W + 1)'(coord_a) - (COORD_W + 1)'(coord_b);
    assign mag     = diff[COORD_W] ? (COORD_W + 1)'(-diff) : (COORD_W + 1)'(diff);
    assign sq_term = mag[COORD_W-1:0] * mag[COORD_W-1:0];
    assign dist_sq = root_q8 * root_q8;

    assign lhs = CMPW'({num_reg, {THR_FRAC{1'b0}}});
    assign rhs = (CMPW'(phi_reg) << HALF) + CMPW'(plo_reg);

    assign reg_col     = c_reg - CW'(WINDOW_HALF);
    assign reg_col_ext = {{COL_W{1'b0}}, reg_col};
    assign k_col_ext   = {{COL_W{1'b0}}, k_reg};
    assign out_free    = !out_valid_reg || flags.ready;

    prefd_sqrt u_sqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.sqrt_start),
        .value ({sq_reg, 16'b0}),
        .root  (root_q8),
        .busy  (root_busy)
    );

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < WL; i++)
            begin
                win_reg[i] <= '0;
            end
            counter_reg   <= '0;
            out_valid_reg <= 1'b0;
            thr_reg       <= THR_RESET;
        end
        else
        begin
            if (cfg_write_en)
            begin
                thr_reg <= cfg_write_data;
            end
            if (cmd.accept)
            begin
                for (int i = 0; i < WL - 1; i++)
                begin
                    win_reg[i] <= win_reg[i+1];
                end
                win_reg[WL-1] <= '{x: point_x, y: point_y, z: point_z};
                counter_reg   <= last_in ? '0 : counter_reg + CW'(1);
            end
            else if (cmd.row_clear)
            begin
                for (int i = 0; i < WL; i++)
                begin
                    win_reg[i] <= '0;
                end
            end
            if (cmd.emit_reg || cmd.emit_flush)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (flags.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // arithmetic and payload
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            c_reg       <= counter_reg;
            last_reg    <= last_in;
            c_ge_w_reg  <= ge_w_in;
            c_ge_2w_reg <= ge_2w_in;
            k_reg       <= ge_w_in ? counter_reg - CW'(WINDOW_HALF) + CW'(1) : '0;
            nb_reg      <= '0;
            axis_reg    <= AXIS_X;
            sq_reg      <= '0;
            s_reg       <= '0;
            q_reg       <= '0;
        end
        if (cmd.diff_step)
        begin
            sq_reg   <= sq_reg + SQ_W'(sq_term);
            axis_reg <= axis_reg + 2'd1;
        end
        if (cmd.accum)
        begin
            s_reg    <= s_reg + SW'(root_q8);
            q_reg    <= q_reg + QW'(dist_sq);
            sq_reg   <= '0;
            axis_reg <= AXIS_X;
            nb_reg   <= nb_reg + NBC'(1);
        end
        if (cmd.fin_square)
        begin
            s2_reg <= s_reg * s_reg;
            nq_reg <= NQW'(q_reg) * NQW'(NB);
        end
        if (cmd.fin_mul_lo)
        begin
            num_reg <= nq_reg - NQW'(s2_reg);
            plo_reg <= thr_reg * s2_reg[HALF-1:0];
        end
        if (cmd.fin_mul_hi)
        begin
            phi_reg <= thr_reg * s2_reg[S2W-1:HALF];
        end
        if (cmd.fin_compare)
        begin
            edge_reg <= (s_reg != '0) && (lhs > rhs);
        end
        if (cmd.emit_reg)
        begin
            out_flag_reg <= c_ge_2w_reg && edge_reg;
            out_col_reg  <= reg_col_ext[COL_W-1:0];
            out_done_reg <= 1'b0;
        end
        else if (cmd.emit_flush)
        begin
            out_flag_reg <= 1'b0;
            out_col_reg  <= k_col_ext[COL_W-1:0];
            out_done_reg <= (k_reg == c_reg);
            k_reg        <= k_reg + CW'(1);
        end
    end

    assign flags.valid        = out_valid_reg;
    assign flags.edge_flag    = out_flag_reg;
    assign flags.column_index = out_col_reg;
    assign flags.row_done     = out_done_reg;

    assign st.last       = last_reg;
    assign st.c_ge_w     = c_ge_w_reg;
    assign st.c_ge_2w    = c_ge_2w_reg;
    assign st.axis_last  = (axis_reg == AXIS_Z);
    assign st.sqrt_done  = !root_busy;
    assign st.nb_last    = (32'(nb_reg) == 32'(NB - 1));
    assign st.flush_last = (k_reg == c_reg);
    assign st.out_free   = out_free;

endmodule

`default_nettype wire

// File: rtl/core/prefd_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
`include "point_row_edge_feature_detector_core_macros.svh"
// ----------------------------------------------------------------------------
// prefd_ctrl
// Sequencer: distance loop over the neighbours, test, result emission.
// ----------------------------------------------------------------------------
module prefd_ctrl (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    in_valid,
    output logic                         in_ready,
    input  wire prefd_pkg::ctrl_status_t st,
    output prefd_pkg::ctrl_cmd_t         cmd
);
    import prefd_pkg::*;

    typedef enum logic [11:0] {
        S_IDLE       = 12'b0000_0000_0001,
        S_DISPATCH   = 12'b0000_0000_0010,
        S_DIFF       = 12'b0000_0000_0100,
        S_ROOT_START = 12'b0000_0000_1000,
        S_ROOT       = 12'b0000_0001_0000,
        S_ACCUM      = 12'b0000_0010_0000,
        S_SQUARE     = 12'b0000_0100_0000,
        S_MUL_LO     = 12'b0000_1000_0000,
        S_MUL_HI     = 12'b0001_0000_0000,
        S_COMPARE    = 12'b0010_0000_0000,
        S_EMIT       = 12'b0100_0000_0000,
        S_FLUSH      = 12'b1000_0000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                priority if (st.c_ge_2w)
                    state_next = S_DIFF;
                else if (st.c_ge_w)
                    state_next = S_EMIT;
                else if (st.last)
                    state_next = S_FLUSH;
                else
                    state_next = S_IDLE;
            end
            S_DIFF:
            begin
                cmd.diff_step = 1'b1;
                if (st.axis_last)
                begin
                    state_next = S_ROOT_START;
                end
            end
            S_ROOT_START:
            begin
                cmd.sqrt_start = 1'b1;
                state_next     = S_ROOT;
            end
            S_ROOT:
            begin
                if (st.sqrt_done)
                begin
                    state_next = S_ACCUM;
                end
            end
            S_ACCUM:
            begin
                cmd.accum  = 1'b1;
                state_next = st.nb_last ? S_SQUARE : S_DIFF;
            end
            S_SQUARE:
            begin
                cmd.fin_square = 1'b1;
                state_next     = S_MUL_LO;
            end
            S_MUL_LO:
            begin
                cmd.fin_mul_lo = 1'b1;
                state_next     = S_MUL_HI;
            end
            S_MUL_HI:
            begin
                cmd.fin_mul_hi = 1'b1;
                state_next     = S_COMPARE;
            end
            S_COMPARE:
            begin
                cmd.fin_compare = 1'b1;
                state_next      = S_EMIT;
            end
            S_EMIT:
            begin
                if (st.out_free)
                begin
                    cmd.emit_reg = 1'b1;
                    state_next   = st.last ? S_FLUSH : S_IDLE;
                end
            end
            S_FLUSH:
            begin
                if (st.out_free)
                begin
                    cmd.emit_flush = 1'b1;
                    if (st.flush_last)
                    begin
                        cmd.row_clear = 1'b1;
                        state_next    = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    `PREFD_ASSERT_IMPL(a_load_when_free, cmd.emit_reg || cmd.emit_flush, st.out_free)
    `PREFD_ASSERT_NEXT(a_accept_dispatch, in_valid && in_ready, state_reg == S_DISPATCH)
    `PREFD_ASSERT_NEXT(a_root_goes_busy, cmd.sqrt_start, !st.sqrt_done)

endmodule

`default_nettype wire
